[hdl/huffman_stream_decoder_core_macros.svh]
// assertion macros used by the decoder core rtl
// depends on a clock named clk and an active-low reset named rst_n in the including module
`ifndef HUFFMAN_STREAM_DECODER_CORE_MACROS_SVH
`define HUFFMAN_STREAM_DECODER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define HSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/hsd_pkg.sv]
// types and codes of the prefix-code stream decoder
// no dependencies
package hsd_pkg;

  // input action codes
  localparam logic [1:0] ACT_TREE  = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_FINAL = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_SYMBOL   = 2'd0;
  localparam logic [1:0] ST_BAD_TREE = 2'd1;
  localparam logic [1:0] ST_EARLY    = 2'd2;

  // tree marker that announces a leaf symbol
  localparam logic [7:0] MARKER_LEAF = 8'd1;

  // code bits in one data byte
  localparam int unsigned BYTE_BITS = 8;

  // node index field width
  localparam int unsigned IDX_W = 9;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_value;
    logic [3:0] valid_bits;
  } in_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] status;
    logic       run_last;
  } out_t;

  // node table entry: leaf flag, left child or leaf symbol, right child
  typedef struct packed {
    logic             leaf;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

endpackage

[hdl/huffman_stream_decoder_core.sv]
// prefix-code stream decoder top level: tree loader, bit walker, node table and stack
// depends on hsd_pkg, hsd_result_stage and huffman_stream_decoder_core_macros.svh
//
//  channel  | ports                          | payload
//  ---------+--------------------------------+-------------------------------------
//  input    | in_valid, in_ready, in_data    | action, byte_value, valid_bits
//  result   | out_valid, out_ready, out_data | symbol, status, run_last
//
// a tree byte goes through stack read, parent read-modify-write and new node write,
//   or to a report state for a bad tree; early data goes to a report state
// a data byte does one node table read per code bit over one read port, plus entry,
//   close and flush; an empty final byte returns to loading straight from idle
// in_ready is high only while the sequencer is idle; results wait in an output register,
//   and result stalls hold the sequencer; reset is synchronous, memories undefined
`include "huffman_stream_decoder_core_macros.svh"

module huffman_stream_decoder_core #(
  parameter int NODE_CAPACITY  = 512,
  parameter int STACK_CAPACITY = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hsd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hsd_pkg::out_t out_data
);

  localparam int NW   = $clog2(NODE_CAPACITY);
  localparam int NUW  = $clog2(NODE_CAPACITY + 1);
  localparam int SW   = (STACK_CAPACITY > 2) ? $clog2(STACK_CAPACITY) : 1;
  localparam int SCW  = $clog2(STACK_CAPACITY + 1);
  localparam int IW   = hsd_pkg::IDX_W;
  localparam logic [IW:0]    CAP_EXT  = (IW + 1)'(NODE_CAPACITY);
  localparam logic [NUW-1:0] NODE_CAP = NUW'(NODE_CAPACITY);
  localparam logic [SCW-1:0] STK_CAP  = SCW'(STACK_CAPACITY);
  localparam logic [3:0]     FULL_BITS = 4'(hsd_pkg::BYTE_BITS);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_STK    = 7'b0000010,
    S_PAR    = 7'b0000100,
    S_NEW    = 7'b0001000,
    S_REPORT = 7'b0010000,
    S_WALK   = 7'b0100000,
    S_FLUSH  = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    PH_MARKER = 3'b001,
    PH_SYMBOL = 3'b010,
    PH_DECODE = 3'b100
  } phase_t;

  // control registers
  state_t         state_r, state_nxt;
  phase_t         phase_r, phase_nxt;
  logic [SCW-1:0] sc_r, sc_nxt;
  logic [NUW-1:0] nu_r, nu_nxt;
  logic           rdp_r, rdp_nxt;
  logic           pend_v_r, pend_v_nxt;

  // working registers
  logic           leaf_r, leaf_nxt;
  logic [7:0]     sym_r, sym_nxt;
  logic [IW-1:0]  top_r, top_nxt;
  logic [1:0]     status_r, status_nxt;
  logic [7:0]     bits_r, bits_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic           final_r, final_nxt;
  logic [7:0]     pend_sym_r, pend_sym_nxt;
  hsd_pkg::node_t cur_r, cur_nxt;
  hsd_pkg::node_t root_r, root_nxt;

  // node table memory
  hsd_pkg::node_t node_mem [NODE_CAPACITY];
  logic           tbl_we;
  logic [NW-1:0]  tbl_waddr;
  hsd_pkg::node_t tbl_wdata;
  logic           tbl_re;
  logic [NW-1:0]  tbl_raddr;
  hsd_pkg::node_t tbl_q_r;

  // pending stack memory
  logic [IW-1:0]  stk_mem [STACK_CAPACITY];
  logic           stk_we;
  logic [SW-1:0]  stk_waddr;
  logic [IW-1:0]  stk_wdata;
  logic           stk_re;
  logic [SW-1:0]  stk_raddr;
  logic [IW-1:0]  stk_q_r;

  // result stage interface
  logic           res_load;
  hsd_pkg::out_t  res_data;
  logic           res_free;

  // effective tree state when a tree byte arrives (decode phase restarts loading)
  phase_t         ph_eff;
  logic [SCW-1:0] sc_eff;
  logic [NUW-1:0] nu_eff;
  logic [SCW-1:0] sc_dec;
  logic [3:0]     nbits;

  // parent update and walk step
  hsd_pkg::node_t par_upd;
  logic           par_pop;
  logic           leaf_hit;
  hsd_pkg::node_t walk_e;
  logic [IW-1:0]  walk_idx;
  logic [IW-1:0]  walk_next;
  hsd_pkg::node_t new_node;

  always_comb begin
    if (phase_r == PH_DECODE) begin
      ph_eff = PH_MARKER;
      sc_eff = '0;
      nu_eff = '0;
    end else begin
      ph_eff = phase_r;
      sc_eff = sc_r;
      nu_eff = nu_r;
    end
  end

  assign sc_dec = sc_eff - SCW'(1);

  // code bits used by a data byte
  always_comb begin
    if (in_data.action == hsd_pkg::ACT_DATA) begin
      nbits = FULL_BITS;
    end else if (in_data.valid_bits > FULL_BITS) begin
      nbits = FULL_BITS;
    end else begin
      nbits = in_data.valid_bits;
    end
  end

  // parent gets the new node as left child first, then right child and leaves the stack
  always_comb begin
    par_upd = tbl_q_r;
    par_pop = (tbl_q_r.left != '0);
    if (par_pop) begin
      par_upd.right = IW'(nu_r);
    end else begin
      par_upd.left = IW'(nu_r);
    end
  end

  always_comb begin
    new_node = '0;
    if (leaf_r) begin
      new_node.leaf = 1'b1;
      new_node.left = IW'(sym_r);
    end
  end

  // one tree step per cycle unless the result slot stalls; a leaf restarts at the root
  assign leaf_hit  = rdp_r && tbl_q_r.leaf;
  assign walk_e    = leaf_hit ? root_r : (rdp_r ? tbl_q_r : cur_r);
  assign walk_idx  = bits_r[7] ? walk_e.right : walk_e.left;
  assign walk_next = ({1'b0, walk_idx} >= CAP_EXT) ? '0 : walk_idx;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    sc_nxt       = sc_r;
    nu_nxt       = nu_r;
    rdp_nxt      = rdp_r;
    pend_v_nxt   = pend_v_r;
    leaf_nxt     = leaf_r;
    sym_nxt      = sym_r;
    top_nxt      = top_r;
    status_nxt   = status_r;
    bits_nxt     = bits_r;
    cnt_nxt      = cnt_r;
    final_nxt    = final_r;
    pend_sym_nxt = pend_sym_r;
    cur_nxt      = cur_r;
    root_nxt     = root_r;
    tbl_we       = 1'b0;
    tbl_waddr    = '0;
    tbl_wdata    = '0;
    tbl_re       = 1'b0;
    tbl_raddr    = '0;
    stk_we       = 1'b0;
    stk_waddr    = '0;
    stk_wdata    = '0;
    stk_re       = 1'b0;
    stk_raddr    = '0;
    res_load     = 1'b0;
    res_data     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.action)
            hsd_pkg::ACT_TREE: begin
              sc_nxt    = sc_eff;
              nu_nxt    = nu_eff;
              phase_nxt = ph_eff;
              leaf_nxt  = (ph_eff == PH_SYMBOL);
              sym_nxt   = in_data.byte_value;
              priority if (ph_eff == PH_MARKER && in_data.byte_value == hsd_pkg::MARKER_LEAF) begin
                phase_nxt = PH_SYMBOL;
              end else if (nu_eff >= NODE_CAP) begin
                // table overflow
                sc_nxt     = '0;
                nu_nxt     = '0;
                phase_nxt  = PH_MARKER;
                status_nxt = hsd_pkg::ST_BAD_TREE;
                state_nxt  = S_REPORT;
              end else if (nu_eff == '0) begin
                state_nxt = S_NEW;
              end else if (sc_eff == '0) begin
                // no node waits for a child
                sc_nxt     = '0;
                nu_nxt     = '0;
                phase_nxt  = PH_MARKER;
                status_nxt = hsd_pkg::ST_BAD_TREE;
                state_nxt  = S_REPORT;
              end else begin
                stk_re    = 1'b1;
                stk_raddr = sc_dec[SW-1:0];
                state_nxt = S_STK;
              end
            end
            hsd_pkg::ACT_DATA, hsd_pkg::ACT_FINAL: begin
              priority if (phase_r != PH_DECODE) begin
                status_nxt = hsd_pkg::ST_EARLY;
                state_nxt  = S_REPORT;
              end else if (nbits == '0) begin
                // empty final byte drops the walk and returns to loading
                sc_nxt    = '0;
                nu_nxt    = '0;
                phase_nxt = PH_MARKER;
              end else begin
                bits_nxt   = in_data.byte_value;
                cnt_nxt    = nbits;
                final_nxt  = (in_data.action == hsd_pkg::ACT_FINAL);
                rdp_nxt    = 1'b0;
                pend_v_nxt = 1'b0;
                state_nxt  = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // stack top is back; fetch its table entry
      S_STK: begin
        if ({1'b0, stk_q_r} >= CAP_EXT) begin
          sc_nxt     = '0;
          nu_nxt     = '0;
          phase_nxt  = PH_MARKER;
          status_nxt = hsd_pkg::ST_BAD_TREE;
          state_nxt  = S_REPORT;
        end else begin
          top_nxt   = stk_q_r;
          tbl_re    = 1'b1;
          tbl_raddr = stk_q_r[NW-1:0];
          state_nxt = S_PAR;
        end
      end

      // link the new node into its parent
      S_PAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = top_r[NW-1:0];
        tbl_wdata = par_upd;
        if (top_r == '0) begin
          root_nxt = par_upd;
        end
        if (par_pop) begin
          sc_nxt = sc_r - SCW'(1);
        end
        state_nxt = S_NEW;
      end

      // write the new node, push it if internal
      S_NEW: begin
        priority if ((!leaf_r && sc_r >= STK_CAP) || (leaf_r && nu_r == '0)) begin
          // stack overflow or a tree that is a single leaf
          sc_nxt     = '0;
          nu_nxt     = '0;
          phase_nxt  = PH_MARKER;
          status_nxt = hsd_pkg::ST_BAD_TREE;
          state_nxt  = S_REPORT;
        end else begin
          tbl_we    = 1'b1;
          tbl_waddr = nu_r[NW-1:0];
          tbl_wdata = new_node;
          if (nu_r == '0) begin
            root_nxt = new_node;
          end
          nu_nxt = nu_r + NUW'(1);
          if (!leaf_r) begin
            stk_we    = 1'b1;
            stk_waddr = sc_r[SW-1:0];
            stk_wdata = IW'(nu_r);
            sc_nxt    = sc_r + SCW'(1);
          end
          if (leaf_r && sc_r == '0) begin
            phase_nxt = PH_DECODE;
            cur_nxt   = root_r;
          end else begin
            phase_nxt = PH_MARKER;
          end
          state_nxt = S_IDLE;
        end
      end

      S_REPORT: begin
        if (res_free) begin
          res_load          = 1'b1;
          res_data.symbol   = '0;
          res_data.status   = status_r;
          res_data.run_last = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      // one code bit a cycle unless a leaf finds the result slot busy; a symbol waits one leaf for run_last
      S_WALK: begin
        if (!(leaf_hit && pend_v_r && !res_free)) begin
          if (leaf_hit) begin
            if (pend_v_r) begin
              res_load          = 1'b1;
              res_data.symbol   = pend_sym_r;
              res_data.status   = hsd_pkg::ST_SYMBOL;
              res_data.run_last = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_sym_nxt = tbl_q_r.left[7:0];
          end
          cur_nxt = walk_e;
          if (cnt_r != '0) begin
            tbl_re    = 1'b1;
            tbl_raddr = walk_next[NW-1:0];
            bits_nxt  = {bits_r[6:0], 1'b0};
            cnt_nxt   = cnt_r - 4'd1;
            rdp_nxt   = 1'b1;
          end else begin
            rdp_nxt   = 1'b0;
            state_nxt = S_FLUSH;
          end
        end
      end

      // last symbol of the byte, then a final byte ends decoding
      S_FLUSH: begin
        if (!pend_v_r || res_free) begin
          if (pend_v_r) begin
            res_load          = 1'b1;
            res_data.symbol   = pend_sym_r;
            res_data.status   = hsd_pkg::ST_SYMBOL;
            res_data.run_last = 1'b1;
            pend_v_nxt        = 1'b0;
          end
          if (final_r) begin
            sc_nxt    = '0;
            nu_nxt    = '0;
            phase_nxt = PH_MARKER;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_MARKER;
      sc_r     <= '0;
      nu_r     <= '0;
      rdp_r    <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      sc_r     <= sc_nxt;
      nu_r     <= nu_nxt;
      rdp_r    <= rdp_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    leaf_r     <= leaf_nxt;
    sym_r      <= sym_nxt;
    top_r      <= top_nxt;
    status_r   <= status_nxt;
    bits_r     <= bits_nxt;
    cnt_r      <= cnt_nxt;
    final_r    <= final_nxt;
    pend_sym_r <= pend_sym_nxt;
    cur_r      <= cur_nxt;
    root_r     <= root_nxt;
  end

  // node table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      node_mem[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_q_r <= node_mem[tbl_raddr];
    end
  end

  // pending stack: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q_r <= stk_mem[stk_raddr];
    end
  end

  hsd_result_stage u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .load_data (res_data),
    .slot_free (res_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // stack and table fill never pass their capacity
  `HSD_ASSERT_IMP(a_stack_bound, 1'b1, sc_r <= STK_CAP, "pending stack count beyond capacity")
  `HSD_ASSERT_IMP(a_table_bound, 1'b1, nu_r <= NODE_CAP, "node count beyond capacity")
  // a complete tree leaves no node waiting for a child
  `HSD_ASSERT_IMP(a_decode_empty, phase_r == PH_DECODE && state_r == S_IDLE, sc_r == '0,
                  "decode phase with pending internal nodes")
  // no symbol is held back once a byte is finished
  `HSD_ASSERT_IMP(a_no_pend_idle, state_r == S_IDLE, !pend_v_r,
                  "pending symbol left while idle")
  // a byte never asks for more than eight steps
  `HSD_ASSERT_NXT(a_walk_count, state_r == S_IDLE && state_nxt == S_WALK, cnt_r <= FULL_BITS,
                  "walk loaded with more than eight code bits")

endmodule

[hdl/hsd_result_stage.sv]
// result output register between the decoder sequencer and the result channel
// depends on hsd_pkg
module hsd_result_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  hsd_pkg::out_t load_data,
  output logic          slot_free,
  output logic          out_valid,
  input  logic          out_ready,
  output hsd_pkg::out_t out_data
);

  logic          valid_r;
  logic          valid_nxt;
  hsd_pkg::out_t data_r;

  // slot opens when empty or when the held transaction leaves this cycle
  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[tb/huffman_stream_decoder_core_test.sv]
// self-checking testbench for the prefix-code stream decoder core
// depends on hsd_pkg and huffman_stream_decoder_core; carries its own decoder predictor
`timescale 1ns / 100ps

module huffman_stream_decoder_core_test;

  localparam int NODE_CAP     = 512;
  localparam int STACK_CAP    = 256;
  localparam int SETTLE_TICKS = 40;
  localparam int DRAIN_LIMIT  = 200000;

  typedef enum logic [1:0] {LOAD_MARKER, LOAD_SYMBOL, WALKING} load_state_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  hsd_pkg::in_t   in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  hsd_pkg::out_t  out_data;

  // predictor state: tree under construction and the walk position
  hsd_pkg::node_t tree_nodes [NODE_CAP];
  logic [8:0]     open_parents [STACK_CAP];
  int unsigned    open_count = 0;
  int unsigned    nodes_made = 0;
  load_state_t    load_state = LOAD_MARKER;
  logic [8:0]     walk_idx = '0;

  // results still owed by the block, oldest first
  hsd_pkg::out_t awaited_results [$];

  bit          idle_on = 1'b0;
  int          stall_left = 0;
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned symbols_seen = 0;
  int unsigned bad_trees_seen = 0;
  int unsigned early_seen = 0;

  huffman_stream_decoder_core #(
    .NODE_CAPACITY (NODE_CAP),
    .STACK_CAPACITY(STACK_CAP)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // run limit
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void restart_tree();
    open_count = 0;
    nodes_made = 0;
    load_state = LOAD_MARKER;
    walk_idx   = '0;
  endfunction

  // link a new node under the pending parent in preorder; 0 on overflow or no open parent
  function automatic bit attach_node(input bit is_leaf, input logic [7:0] sym);
    int unsigned n;
    logic [8:0]  parent;
    n = nodes_made;
    if (n >= NODE_CAP) return 1'b0;
    if (n != 0) begin
      if (open_count == 0) return 1'b0;
      parent = open_parents[open_count - 1];
      if (tree_nodes[parent].left == '0) begin
        tree_nodes[parent].left = n[8:0];
      end else begin
        tree_nodes[parent].right = n[8:0];
        open_count--;
      end
    end
    if (!is_leaf && open_count >= STACK_CAP) return 1'b0;
    tree_nodes[n].leaf  = is_leaf;
    tree_nodes[n].left  = is_leaf ? {1'b0, sym} : '0;
    tree_nodes[n].right = '0;
    nodes_made = n + 1;
    if (!is_leaf) begin
      open_parents[open_count] = n[8:0];
      open_count++;
    end
    return 1'b1;
  endfunction

  // expected results of one accepted input transaction
  function automatic void predict_decode(input hsd_pkg::in_t item);
    hsd_pkg::out_t batch [8];
    int unsigned   count;
    int unsigned   nbits;
    bit            ok;
    bit            is_leaf;
    bit            code_bit;
    logic [8:0]    child;
    count   = 0;
    is_leaf = 1'b0;
    if (item.action == hsd_pkg::ACT_NONE) return;
    if (item.action == hsd_pkg::ACT_TREE) begin
      if (load_state == WALKING) restart_tree();
      if (load_state == LOAD_MARKER) begin
        if (item.byte_value == hsd_pkg::MARKER_LEAF) begin
          load_state = LOAD_SYMBOL;
          return;
        end
        ok = attach_node(1'b0, 8'h00);
      end else begin
        is_leaf = 1'b1;
        ok = attach_node(1'b1, item.byte_value);
      end
      // overflow or a lone leaf as root
      if (!ok || (is_leaf && nodes_made == 1)) begin
        restart_tree();
        awaited_results.push_back('{symbol: 8'h00, status: hsd_pkg::ST_BAD_TREE,
                                    run_last: 1'b1});
        return;
      end
      if (is_leaf && open_count == 0) begin
        load_state = WALKING;
        walk_idx   = '0;
      end else begin
        load_state = LOAD_MARKER;
      end
      return;
    end
    // data with no complete tree
    if (load_state != WALKING) begin
      awaited_results.push_back('{symbol: 8'h00, status: hsd_pkg::ST_EARLY, run_last: 1'b1});
      return;
    end
    if (item.action == hsd_pkg::ACT_DATA) nbits = hsd_pkg::BYTE_BITS;
    else nbits = (item.valid_bits > hsd_pkg::BYTE_BITS) ? hsd_pkg::BYTE_BITS : item.valid_bits;
    // walk msb first, emit on each leaf
    for (int unsigned i = 0; i < nbits; i++) begin
      code_bit = item.byte_value[7 - i];
      child = code_bit ? tree_nodes[walk_idx].right : tree_nodes[walk_idx].left;
      if (tree_nodes[child].leaf) begin
        batch[count] = '{symbol: tree_nodes[child].left[7:0], status: hsd_pkg::ST_SYMBOL,
                         run_last: 1'b0};
        count++;
        walk_idx = '0;
      end else begin
        walk_idx = child;
      end
    end
    if (item.action == hsd_pkg::ACT_FINAL) restart_tree();
    if (count > 0) batch[count - 1].run_last = 1'b1;
    for (int unsigned i = 0; i < count; i++) awaited_results.push_back(batch[i]);
  endfunction

  // result checker and receiver stall bursts
  always @(posedge clk) begin
    hsd_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction with nothing expected: symbol %0h status %0d last %0b",
               out_data.symbol, out_data.status, out_data.run_last);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.symbol !== want.symbol) begin
          $error("symbol mismatch: expected %0h, actual %0h", want.symbol, out_data.symbol);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.run_last !== want.run_last) begin
          $error("run_last mismatch: expected %0b, actual %0b", want.run_last,
                 out_data.run_last);
          fail_count++;
        end
        case (want.status)
          hsd_pkg::ST_SYMBOL:   symbols_seen++;
          hsd_pkg::ST_BAD_TREE: bad_trees_seen++;
          default:              early_seen++;
        endcase
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = int'($urandom_range(1, 18)) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one input transaction; valid stays high for a following send
  task automatic send_item(input logic [1:0] act, input logic [7:0] value,
                           input logic [3:0] vbits);
    hsd_pkg::in_t item;
    item.action     = act;
    item.byte_value = value;
    item.valid_bits = vbits;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_decode(item);
    if (act != hsd_pkg::ACT_NONE) items_sent++;
  endtask

  // hold off the sender until every owed result has come
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  function automatic logic [7:0] random_marker();
    logic [7:0] v;
    v = 8'($urandom_range(0, 254));
    if (v >= hsd_pkg::MARKER_LEAF) v++;
    return v;
  endfunction

  task automatic send_internal(input logic [7:0] marker);
    send_item(hsd_pkg::ACT_TREE, marker, 4'($urandom_range(0, 15)));
  endtask

  task automatic send_leaf(input logic [7:0] sym);
    send_item(hsd_pkg::ACT_TREE, hsd_pkg::MARKER_LEAF, 4'($urandom_range(0, 15)));
    send_item(hsd_pkg::ACT_TREE, sym, 4'($urandom_range(0, 15)));
  endtask

  // random full binary tree in preorder with the given leaf count
  task automatic send_random_tree(input int unsigned leaves);
    int unsigned open_slots;
    int unsigned internals_left;
    int unsigned bias;
    open_slots     = 1;
    internals_left = leaves - 1;
    bias           = $urandom_range(15, 90);
    while (open_slots != 0) begin
      if (internals_left != 0 && (open_slots == 1 || $urandom_range(0, 99) < bias)) begin
        send_internal(random_marker());
        internals_left--;
        open_slots++;
      end else begin
        send_leaf(8'($urandom_range(0, 255)));
        open_slots--;
      end
    end
  endtask

  // data while no tree is loaded, and the unused action
  task automatic test_early_data();
    send_item(hsd_pkg::ACT_DATA, 8'h00, 4'h0);
    send_item(hsd_pkg::ACT_FINAL, 8'hFF, 4'hF);
    send_item(hsd_pkg::ACT_NONE, 8'hA5, 4'h5);
  endtask

  // a root that is a leaf is rejected
  task automatic test_single_leaf();
    send_leaf(8'h5A);
    send_item(hsd_pkg::ACT_DATA, 8'h3C, 4'h8);
  endtask

  // two-leaf trees: eight symbols per byte, final byte lengths
  task automatic test_two_leaf_tree();
    send_internal(8'h00);
    send_leaf(8'h00);
    send_leaf(8'hFF);
    send_item(hsd_pkg::ACT_DATA, 8'h00, 4'h0);
    send_item(hsd_pkg::ACT_DATA, 8'hFF, 4'hA);
    send_item(hsd_pkg::ACT_FINAL, 8'hA5, 4'hF);
    send_item(hsd_pkg::ACT_DATA, 8'h11, 4'h1);
    send_internal(8'hFF);
    send_leaf(hsd_pkg::MARKER_LEAF);
    send_leaf(8'h80);
    send_item(hsd_pkg::ACT_FINAL, 8'hFF, 4'h0);
    send_item(hsd_pkg::ACT_DATA, 8'h55, 4'h7);
  endtask

  // carry-over walks, tree byte while decoding, dropped partial on final
  task automatic test_three_leaf_tree();
    send_internal(8'h02);
    send_leaf(8'h41);
    send_internal(8'hFE);
    send_leaf(8'h42);
    send_leaf(8'h43);
    send_item(hsd_pkg::ACT_DATA, 8'h01, 4'h3);
    send_item(hsd_pkg::ACT_DATA, 8'h80, 4'h9);
    send_item(hsd_pkg::ACT_DATA, 8'h6D, 4'h2);
    send_item(hsd_pkg::ACT_DATA, 8'h01, 4'h4);
    // partial walk pending: a tree byte starts over
    send_internal(8'h00);
    send_leaf(8'h10);
    send_leaf(8'h20);
    send_item(hsd_pkg::ACT_FINAL, 8'hC0, 4'h1);
    send_internal(8'h07);
    send_leaf(8'h41);
    send_internal(8'h08);
    send_leaf(8'h42);
    send_leaf(8'h43);
    send_item(hsd_pkg::ACT_FINAL, 8'h80, 4'h1);
    send_item(hsd_pkg::ACT_DATA, 8'h00, 4'h6);
  endtask

  // too many internal nodes waiting for a child
  task automatic test_stack_overflow();
    repeat (STACK_CAP + 1) send_internal(random_marker());
    send_random_tree(3);
    send_item(hsd_pkg::ACT_DATA, 8'($urandom_range(0, 255)), 4'h8);
  endtask

  // caterpillar tree that fills the node table, then one node more
  task automatic test_table_overflow();
    repeat (NODE_CAP / 2) begin
      send_internal(random_marker());
      send_leaf(8'($urandom_range(0, 255)));
    end
    send_internal(random_marker());
    send_random_tree(2);
    send_item(hsd_pkg::ACT_DATA, 8'($urandom_range(0, 255)), 4'h0);
  endtask

  // mostly well-formed streams with random content, some noise
  task automatic test_random_streams(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 7) == 0) send_random_tree($urandom_range(11, 40));
        else send_random_tree($urandom_range(2, 10));
        repeat ($urandom_range(0, 8))
          send_item(hsd_pkg::ACT_DATA, 8'($urandom_range(0, 255)),
                    4'($urandom_range(0, 15)));
        if ($urandom_range(0, 3) != 0)
          send_item(hsd_pkg::ACT_FINAL, 8'($urandom_range(0, 255)),
                    4'($urandom_range(0, 15)));
      end else if (pick < 78) begin
        send_item(hsd_pkg::ACT_NONE, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      end else if (pick < 86) begin
        send_item($urandom_range(0, 1) ? hsd_pkg::ACT_DATA : hsd_pkg::ACT_FINAL,
                  8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      end else if (pick < 93) begin
        // loose tree bytes, may leave a tree half built
        repeat ($urandom_range(1, 6))
          send_item(hsd_pkg::ACT_TREE,
                    ($urandom_range(0, 3) == 0) ? hsd_pkg::MARKER_LEAF : random_marker(),
                    4'($urandom_range(0, 15)));
      end else begin
        send_random_tree(1);
      end
    end
  endtask

  initial begin
    int unsigned guard;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_early_data();
    test_single_leaf();
    test_two_leaf_tree();
    test_three_leaf_tree();
    wait_results_drained();
    idle_on = 1'b1;
    test_stack_overflow();
    test_table_overflow();
    test_random_streams(150);
    wait_results_drained();
    test_random_streams(150);
    idle_on = 1'b0;
    test_random_streams(50);

    // drain and settle
    in_valid <= 1'b0;
    guard = 0;
    while (awaited_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (awaited_results.size() != 0) begin
      $error("%0d expected result transactions never arrived", awaited_results.size());
      fail_count++;
    end
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("covered %0d input transactions: tree bytes, full and final data bytes",
             items_sent);
    $display("checked %0d symbols, %0d tree errors, %0d early data reports",
             symbols_seen, bad_trees_seen, early_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
